FILE: hdl/spd_pkg.sv
// Package: shared widths, item kind codes, controller states and control structs.
`timescale 1ns / 1ps
package spd_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 4;
  localparam int LEN_W  = 5;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FLUSH,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic load;
    logic append;
    logic drop;
    logic clear;
    logic emit_word;
    logic emit_mark;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic prefix_ok;
    logic full_match;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hdl/spd_if.sv
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
interface spd_item_if import spd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [SLOT_W-1:0]         slot;
  logic signed [WORD_W-1:0]  word;
  modport source (output valid, kind, slot, word, input ready);
  modport sink   (input valid, kind, slot, word, output ready);
endinterface

interface spd_result_if import spd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  kept_word;
  logic                      end_marker;
  modport source (output valid, kept_word, end_marker, input ready);
  modport sink   (input valid, kept_word, end_marker, output ready);
endinterface

interface spd_cfg_if import spd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/stream_pattern_deleter.sv
// Top level: deletes non-overlapping pattern occurrences from a word stream.
// Load and unused-kind items leave the controller idle; ready stays high, so they can follow back to back.
// A data item is appended, then checked; buffered words that break the prefix are emitted (at most MAX_PATTERN).
// An end item flushes the buffered words, then sends an end marker; each result waits in one output register.
// The rate is set by the single shift buffer that emits one word per cycle while the output register is free.
// Synchronous active-high reset clears length, match count, state and output valid.
`timescale 1ns / 1ps
module stream_pattern_deleter import spd_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  spd_cfg_if.sink       cfg,
  spd_item_if.sink      items,
  spd_result_if.source  results
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg.ready = 1'b1;

  spd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_kind  (items.kind),
    .item_ready (items.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  spd_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.data),
    .item_slot (items.slot),
    .item_word (items.word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_word  (results.kept_word),
    .out_mark  (results.end_marker)
  );

endmodule

FILE: hdl/spd_ctrl.sv
// Controller: sequences load, match check, drain, flush and end marker.
`timescale 1ns / 1ps
module spd_ctrl import spd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [KIND_W-1:0] item_kind,
  output logic              item_ready,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);

  state_t state, state_next;
  logic   accept;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (item_kind)
            KIND_DATA: state_next = ST_CHECK;
            KIND_END:  state_next = ST_FLUSH;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts.count_zero || sts.prefix_ok) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.count_zero) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load   = accept && (item_kind == KIND_LOAD);
        cmd.append = accept && (item_kind == KIND_DATA);
      end
      ST_CHECK: begin
        if (!sts.count_zero) begin
          if (sts.prefix_ok) begin
            cmd.clear = sts.full_match;
          end else if (sts.out_free) begin
            cmd.emit_word = 1'b1;
            cmd.drop      = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.count_zero && sts.out_free) begin
          cmd.emit_word = 1'b1;
          cmd.drop      = 1'b1;
        end
      end
      ST_MARK: begin
        cmd.emit_mark = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/spd_dp.sv
// Datapath: pattern store, partial-match buffer, length register and output register.
`timescale 1ns / 1ps
module spd_dp import spd_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [LEN_W-1:0]          cfg_data,
  input  logic [SLOT_W-1:0]         item_slot,
  input  logic signed [WORD_W-1:0]  item_word,
  input  dp_cmd_t                   cmd,
  output dp_sts_t                   sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [WORD_W-1:0]  out_word,
  output logic                      out_mark
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_PATTERN);

  logic [WORD_W-1:0]  pattern_store [MAX_PATTERN];
  logic [WORD_W-1:0]  match_buffer  [MAX_PATTERN];
  logic [CW-1:0]      matched_count;
  logic [LEN_W-1:0]   pattern_length;
  logic [LW-1:0]      len_ext, eff_len, count_ext;
  logic [MAX_PATTERN-1:0] eq;
  logic               slot_ok;

  assign slot_ok   = (SW'(item_slot) < SW'(MAX_PATTERN));
  assign len_ext   = LW'(pattern_length);
  assign eff_len   = (len_ext > MAX_L) ? MAX_L : len_ext;
  assign count_ext = LW'(matched_count);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i] = (CW'(i) >= matched_count) || (match_buffer[i] == pattern_store[i]);
    end
  end

  assign sts.count_zero = (matched_count == '0);
  assign sts.prefix_ok  = (count_ext <= eff_len) && (&eq);
  assign sts.full_match = (count_ext == eff_len);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_we) begin
      pattern_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      pattern_store[IW'(item_slot)] <= item_word;
    end
  end

  // After each check the count stays below MAX_PATTERN, so an append always has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      matched_count <= '0;
    end else if (cmd.append) begin
      matched_count <= matched_count + CW'(1);
    end else if (cmd.drop) begin
      matched_count <= matched_count - CW'(1);
    end else if (cmd.clear) begin
      matched_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      match_buffer[matched_count[IW-1:0]] <= item_word;
    end else if (cmd.drop) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        match_buffer[i] <= match_buffer[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_word || cmd.emit_mark) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_word) begin
      out_word <= match_buffer[0];
      out_mark <= 1'b0;
    end else if (cmd.emit_mark) begin
      out_word <= '0;
      out_mark <= 1'b1;
    end
  end

endmodule

FILE: hdl/spd_checker.sv
// Checker: port-level properties of the pattern deleter, bound to the top level.
`timescale 1ns / 1ps
module spd_checker import spd_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [KIND_W-1:0]         in_kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [WORD_W-1:0]  out_word,
  input logic                      out_mark
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_mark))
    else $error("stalled result transaction changed");

  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mark |-> out_word == '0)
    else $error("end marker carries nonzero word");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == KIND_DATA || in_kind == KIND_END) |=> !in_ready)
    else $error("input ready while item still in progress");

endmodule

bind stream_pattern_deleter spd_checker u_spd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_kind   (items.kind),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_word  (results.kept_word),
  .out_mark  (results.end_marker)
);
